>>> src/swpc_pkg.sv
// Shared types, constants and recode table of the surface water pixel classifier.
package swpc_pkg;

    localparam logic [7:0] MASK_FILL_CODE = 8'd255;
    localparam logic [7:0] NO_DATA_CODE   = 8'd255;

    localparam logic [7:0] MASK_SHADOW    = 8'd2;
    localparam logic [7:0] MASK_SNOW      = 8'd3;
    localparam logic [7:0] MASK_CLOUD     = 8'd4;

    localparam logic [7:0] CLASS_NOT_WATER = 8'd0;
    localparam logic [7:0] CLASS_OBSCURED  = 8'd9;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WETNESS      = 4'd0,
        REG_SHADOW       = 4'd1,
        REG_PART1_WET    = 4'd2,
        REG_PART2_WET    = 4'd3,
        REG_PART1_LIMITS = 4'd4,
        REG_PART2_LIMITS = 4'd5,
        REG_SLOPE_LIMIT  = 4'd6,
        REG_FILL         = 4'd7
    } t_reg_index;

    localparam logic [1:0] CLASS_LUT [32] = '{
        2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
        2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
        2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
    };

    typedef struct packed {
        logic signed [15:0] wet_thr;
        logic signed [21:0] shadow_thr;
        logic signed [15:0] part1_wet;
        logic signed [15:0] part2_wet;
        logic        [31:0] part1_limits;
        logic        [31:0] part2_limits;
        logic        [15:0] slope_limit;
        logic signed [15:0] fill;
    } t_cfg;

    typedef struct packed {
        logic               no_data;
        logic signed [16:0] num;
        logic signed [16:0] den;
        logic signed [20:0] awesh;
        logic               vis;
        logic               p1_lim;
        logic               p2_lim;
        logic               steep;
        logic               obscured;
    } t_prep;

    typedef struct packed {
        logic               no_data;
        logic signed [16:0] num;
        logic               den_pos;
        logic               den_neg;
        logic               num_pos;
        logic signed [32:0] prod_wet;
        logic signed [32:0] prod_p1;
        logic signed [32:0] prod_p2;
        logic               vis;
        logic               shadow;
        logic               p1_lim;
        logic               p2_lim;
        logic               steep;
        logic               obscured;
    } t_ratio;

    typedef struct packed {
        logic       no_data;
        logic [4:0] test_bits;
        logic [7:0] raw_class;
        logic [7:0] masked_class;
        logic [7:0] slope_masked_class;
    } t_result;

endpackage

>>> src/swpc_prep.sv
// First stage: band sums, fill detection, limit, slope and mask checks.
module swpc_prep import swpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_blue,
    input  logic signed [15:0] i_green,
    input  logic signed [15:0] i_red,
    input  logic signed [15:0] i_near_infrared,
    input  logic signed [15:0] i_shortwave_one,
    input  logic signed [15:0] i_shortwave_two,
    input  logic        [7:0]  i_mask_code,
    input  logic        [15:0] i_slope_hundredths,
    output t_prep              o_prep
);

    t_prep              r_prep;
    t_prep              n_prep;
    logic signed [16:0] w_gr;
    logic signed [16:0] w_ns;
    logic signed [20:0] w_b4;
    logic signed [20:0] w_g8;
    logic signed [20:0] w_g2;
    logic signed [20:0] w_s4;
    logic signed [20:0] w_s2;
    logic signed [20:0] w_sw2;

    always_comb begin
        w_gr  = $signed({i_green[15], i_green}) + $signed({i_red[15], i_red});
        w_ns  = $signed({i_near_infrared[15], i_near_infrared})
              + $signed({i_shortwave_one[15], i_shortwave_one});
        w_b4  = $signed({{3{i_blue[15]}}, i_blue, 2'b00});
        w_g8  = $signed({{2{i_green[15]}}, i_green, 3'b000});
        w_g2  = $signed({{4{i_green[15]}}, i_green, 1'b0});
        w_s4  = $signed({{2{w_ns[16]}}, w_ns, 2'b00});
        w_s2  = $signed({{3{w_ns[16]}}, w_ns, 1'b0});
        w_sw2 = $signed({{5{i_shortwave_two[15]}}, i_shortwave_two});

        n_prep.no_data = (i_blue == i_cfg.fill) || (i_green == i_cfg.fill)
                      || (i_red == i_cfg.fill) || (i_near_infrared == i_cfg.fill)
                      || (i_shortwave_one == i_cfg.fill)
                      || (i_shortwave_two == i_cfg.fill)
                      || (i_mask_code == MASK_FILL_CODE);
        n_prep.num   = $signed({i_green[15], i_green})
                     - $signed({i_shortwave_one[15], i_shortwave_one});
        n_prep.den   = $signed({i_green[15], i_green})
                     + $signed({i_shortwave_one[15], i_shortwave_one});
        n_prep.awesh = w_b4 + w_g8 + w_g2 - w_s4 - w_s2 - w_sw2;
        n_prep.vis   = w_gr > w_ns;
        n_prep.p1_lim = ($signed({i_shortwave_one[15], i_shortwave_one})
                         < $signed({1'b0, i_cfg.part1_limits[15:0]}))
                     && ($signed({i_near_infrared[15], i_near_infrared})
                         < $signed({1'b0, i_cfg.part1_limits[31:16]}));
        n_prep.p2_lim = ($signed({i_shortwave_two[15], i_shortwave_two})
                         < $signed({1'b0, i_cfg.part2_limits[15:0]}))
                     && ($signed({i_near_infrared[15], i_near_infrared})
                         < $signed({1'b0, i_cfg.part2_limits[31:16]}));
        n_prep.steep = i_slope_hundredths >= i_cfg.slope_limit;
        n_prep.obscured = i_mask_code inside {MASK_SHADOW, MASK_SNOW, MASK_CLOUD};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

>>> src/swpc_ratio.sv
// Second stage: threshold times denominator products and shadow test.
module swpc_ratio import swpc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_cfg   i_cfg,
    input  t_prep  i_prep,
    output t_ratio o_ratio
);

    t_ratio r_ratio;
    t_ratio n_ratio;

    always_comb begin
        n_ratio.no_data  = i_prep.no_data;
        n_ratio.num      = i_prep.num;
        n_ratio.den_pos  = !i_prep.den[16] && (i_prep.den != 17'sd0);
        n_ratio.den_neg  = i_prep.den[16];
        n_ratio.num_pos  = !i_prep.num[16] && (i_prep.num != 17'sd0);
        n_ratio.prod_wet = i_cfg.wet_thr * i_prep.den;
        n_ratio.prod_p1  = i_cfg.part1_wet * i_prep.den;
        n_ratio.prod_p2  = i_cfg.part2_wet * i_prep.den;
        n_ratio.vis      = i_prep.vis;
        n_ratio.shadow   = $signed({i_prep.awesh[20], i_prep.awesh}) > i_cfg.shadow_thr;
        n_ratio.p1_lim   = i_prep.p1_lim;
        n_ratio.p2_lim   = i_prep.p2_lim;
        n_ratio.steep    = i_prep.steep;
        n_ratio.obscured = i_prep.obscured;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ratio <= n_ratio;
        end
    end

    assign o_ratio = r_ratio;

endmodule

>>> src/swpc_class.sv
// Third stage: ratio comparisons, test word, recode and class overrides.
module swpc_class import swpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_ratio  i_ratio,
    output t_result o_result
);

    t_result            r_result;
    t_result            n_result;
    logic signed [33:0] w_num_sh;
    logic               w_wet;
    logic               w_p1;
    logic               w_p2;
    logic        [4:0]  w_bits;
    logic        [7:0]  w_raw;
    logic        [7:0]  w_slope;

    function automatic logic above(input logic signed [33:0] num_sh,
                                   input logic signed [32:0] prod,
                                   input logic den_pos, input logic den_neg,
                                   input logic num_pos);
        logic signed [33:0] p;
        p = $signed({prod[32], prod});
        if (den_pos) begin
            return num_sh > p;
        end else if (den_neg) begin
            return num_sh < p;
        end
        return num_pos;
    endfunction

    always_comb begin
        w_num_sh = $signed({{2{i_ratio.num[16]}}, i_ratio.num, 15'd0});
        w_wet = above(w_num_sh, i_ratio.prod_wet, i_ratio.den_pos, i_ratio.den_neg,
                      i_ratio.num_pos);
        w_p1  = above(w_num_sh, i_ratio.prod_p1, i_ratio.den_pos, i_ratio.den_neg,
                      i_ratio.num_pos);
        w_p2  = above(w_num_sh, i_ratio.prod_p2, i_ratio.den_pos, i_ratio.den_neg,
                      i_ratio.num_pos);
        w_bits = {w_p2 && i_ratio.p2_lim, w_p1 && i_ratio.p1_lim, i_ratio.shadow,
                  i_ratio.vis, w_wet};
        w_raw   = {6'd0, CLASS_LUT[w_bits]};
        w_slope = i_ratio.steep ? CLASS_NOT_WATER : w_raw;

        if (i_ratio.no_data) begin
            n_result.no_data            = 1'b1;
            n_result.test_bits          = 5'd0;
            n_result.raw_class          = NO_DATA_CODE;
            n_result.masked_class       = NO_DATA_CODE;
            n_result.slope_masked_class = NO_DATA_CODE;
        end else begin
            n_result.no_data            = 1'b0;
            n_result.test_bits          = w_bits;
            n_result.raw_class          = w_raw;
            n_result.masked_class       = i_ratio.obscured ? CLASS_OBSCURED : w_raw;
            n_result.slope_masked_class = i_ratio.obscured ? CLASS_OBSCURED : w_slope;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

>>> src/surface_water_pixel_classifier.sv
// Top level of the surface water pixel classifier: config registers and pipeline control.
//
//   channel   direction  handshake              payload
//   pixel     in         i_valid / o_ready      i_blue .. i_slope_hundredths
//   class     out        o_valid / i_ready      o_no_data .. o_slope_masked_class
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// Three register stages (sums, multiplies, recode).
// One pixel enters per cycle while o_ready is high; each stage takes a new item
// whenever it is empty or the stage after it moves on, so bubbles close up under a stall.
// Reset empties the pipeline and loads the register defaults.
module surface_water_pixel_classifier import swpc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [15:0]     i_blue,
    input  logic signed [15:0]     i_green,
    input  logic signed [15:0]     i_red,
    input  logic signed [15:0]     i_near_infrared,
    input  logic signed [15:0]     i_shortwave_one,
    input  logic signed [15:0]     i_shortwave_two,
    input  logic        [7:0]      i_mask_code,
    input  logic        [15:0]     i_slope_hundredths,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_no_data,
    output logic        [4:0]      o_test_bits,
    output logic        [7:0]      o_raw_class,
    output logic        [7:0]      o_masked_class,
    output logic        [7:0]      o_slope_masked_class,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_v1;
    logic    r_v2;
    logic    r_v3;
    logic    w_rdy1;
    logic    w_rdy2;
    logic    w_rdy3;
    t_prep   w_prep;
    t_ratio  w_ratio;
    t_result w_result;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wet_thr      <= 16'sd403;
            r_cfg.shadow_thr   <= 22'sd0;
            r_cfg.part1_wet    <= -16'sd14418;
            r_cfg.part2_wet    <= -16'sd16384;
            r_cfg.part1_limits <= 32'd98305000;
            r_cfg.part2_limits <= 32'd131073000;
            r_cfg.slope_limit  <= 16'd3000;
            r_cfg.fill         <= -16'sd9999;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WETNESS:      r_cfg.wet_thr      <= $signed(i_cfg_data[15:0]);
                REG_SHADOW:       r_cfg.shadow_thr   <= $signed(i_cfg_data[21:0]);
                REG_PART1_WET:    r_cfg.part1_wet    <= $signed(i_cfg_data[15:0]);
                REG_PART2_WET:    r_cfg.part2_wet    <= $signed(i_cfg_data[15:0]);
                REG_PART1_LIMITS: r_cfg.part1_limits <= i_cfg_data;
                REG_PART2_LIMITS: r_cfg.part2_limits <= i_cfg_data;
                REG_SLOPE_LIMIT:  r_cfg.slope_limit  <= i_cfg_data[15:0];
                REG_FILL:         r_cfg.fill         <= $signed(i_cfg_data[15:0]);
                default: begin
                end
            endcase
        end
    end

    swpc_prep u_prep (
        .i_clk              (i_clk),
        .i_en               (w_rdy1 && i_valid),
        .i_cfg              (r_cfg),
        .i_blue             (i_blue),
        .i_green            (i_green),
        .i_red              (i_red),
        .i_near_infrared    (i_near_infrared),
        .i_shortwave_one    (i_shortwave_one),
        .i_shortwave_two    (i_shortwave_two),
        .i_mask_code        (i_mask_code),
        .i_slope_hundredths (i_slope_hundredths),
        .o_prep             (w_prep)
    );

    swpc_ratio u_ratio (
        .i_clk   (i_clk),
        .i_en    (w_rdy2 && r_v1),
        .i_cfg   (r_cfg),
        .i_prep  (w_prep),
        .o_ratio (w_ratio)
    );

    swpc_class u_class (
        .i_clk    (i_clk),
        .i_en     (w_rdy3 && r_v2),
        .i_ratio  (w_ratio),
        .o_result (w_result)
    );

    assign o_valid              = r_v3;
    assign o_no_data            = w_result.no_data;
    assign o_test_bits          = w_result.test_bits;
    assign o_raw_class          = w_result.raw_class;
    assign o_masked_class       = w_result.masked_class;
    assign o_slope_masked_class = w_result.slope_masked_class;

`ifndef SYNTH
    a_no_data_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_data |-> o_test_bits == 5'd0 && o_raw_class == NO_DATA_CODE
            && o_masked_class == NO_DATA_CODE && o_slope_masked_class == NO_DATA_CODE)
        else $error("no-data result carries test bits or a water class");

    a_mask_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_no_data && o_masked_class != o_raw_class
            |-> o_masked_class == CLASS_OBSCURED && o_slope_masked_class == CLASS_OBSCURED)
        else $error("masked class differs from raw class without an obscured override");

    a_slope_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_no_data |-> o_slope_masked_class == o_masked_class
            || o_slope_masked_class == CLASS_NOT_WATER)
        else $error("slope masked class is neither the masked class nor not-water");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_ready && r_v2 |=> r_v3 && r_v2)
        else $error("pipeline stage dropped an item under an output stall");
`endif

endmodule

>>> tb/sv/surface_water_class_checker.sv
// Checker for the surface water pixel classifier: watches the pixel, class and config ports.
`timescale 1ns / 100ps

module surface_water_class_checker import swpc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pix_valid,
    input  logic                   i_pix_ready,
    input  logic signed [15:0]     i_blue,
    input  logic signed [15:0]     i_green,
    input  logic signed [15:0]     i_red,
    input  logic signed [15:0]     i_near_infrared,
    input  logic signed [15:0]     i_shortwave_one,
    input  logic signed [15:0]     i_shortwave_two,
    input  logic        [7:0]      i_mask_code,
    input  logic        [15:0]     i_slope_hundredths,
    input  logic                   i_cls_valid,
    input  logic                   i_cls_ready,
    input  logic                   i_no_data,
    input  logic        [4:0]      i_test_bits,
    input  logic        [7:0]      i_raw_class,
    input  logic        [7:0]      i_masked_class,
    input  logic        [7:0]      i_slope_masked_class,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct {
        logic signed [15:0] wet_thr;
        logic signed [21:0] shadow_thr;
        logic signed [15:0] p1_wet;
        logic signed [15:0] p2_wet;
        logic        [15:0] p1_swir_lim;
        logic        [15:0] p1_nir_lim;
        logic        [15:0] p2_swir_lim;
        logic        [15:0] p2_nir_lim;
        logic        [15:0] slope_lim;
        logic signed [15:0] fill;
    } t_water_cfg;

    typedef struct {
        logic signed [15:0] blue;
        logic signed [15:0] green;
        logic signed [15:0] red;
        logic signed [15:0] nir;
        logic signed [15:0] swir1;
        logic signed [15:0] swir2;
        logic        [7:0]  mask;
        logic        [15:0] slope;
    } t_pixel;

    t_water_cfg cfg;
    t_result    pending_classes [$];
    int         class_count;

    initial begin
        o_fail_count = 0;
        class_count  = 0;
    end

    function automatic void write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WETNESS:      cfg.wet_thr = data[15:0];
            REG_SHADOW:       cfg.shadow_thr = data[21:0];
            REG_PART1_WET:    cfg.p1_wet = data[15:0];
            REG_PART2_WET:    cfg.p2_wet = data[15:0];
            REG_PART1_LIMITS: begin
                cfg.p1_swir_lim = data[15:0];
                cfg.p1_nir_lim  = data[31:16];
            end
            REG_PART2_LIMITS: begin
                cfg.p2_swir_lim = data[15:0];
                cfg.p2_nir_lim  = data[31:16];
            end
            REG_SLOPE_LIMIT:  cfg.slope_lim = data[15:0];
            REG_FILL:         cfg.fill = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic void load_reset_cfg();
        write_cfg(REG_WETNESS, 32'd403);
        write_cfg(REG_SHADOW, 32'd0);
        write_cfg(REG_PART1_WET, -32'sd14418);
        write_cfg(REG_PART2_WET, -32'sd16384);
        write_cfg(REG_PART1_LIMITS, 32'd98305000);
        write_cfg(REG_PART2_LIMITS, 32'd131073000);
        write_cfg(REG_SLOPE_LIMIT, 32'd3000);
        write_cfg(REG_FILL, -32'sd9999);
    endfunction

    // num/den > thr/32768, a zero denominator being signed infinity
    function automatic bit mndwi_above(input longint num, input longint den,
                                       input longint thr);
        if (den > 0)
            return num * 32768 > thr * den;
        if (den < 0)
            return num * 32768 < thr * den;
        return num > 0;
    endfunction

    function automatic logic [7:0] water_class(input logic [4:0] bits);
        case (bits)
            5'd0, 5'd1:                 return 8'd0;
            5'd8, 5'd16, 5'd24:         return 8'd3;
            5'd15, 5'd23, 5'd25, 5'd26,
            5'd27, 5'd28, 5'd29, 5'd30,
            5'd31:                      return 8'd1;
            default:                    return 8'd2;
        endcase
    endfunction

    function automatic t_result classify_pixel(input t_water_cfg c, input t_pixel p);
        t_result r;
        longint  num;
        longint  den;
        longint  awesh4;
        r.no_data   = 1'b0;
        r.test_bits = '0;
        if (p.blue == c.fill || p.green == c.fill || p.red == c.fill ||
            p.nir == c.fill || p.swir1 == c.fill || p.swir2 == c.fill ||
            p.mask == MASK_FILL_CODE) begin
            r.no_data            = 1'b1;
            r.raw_class          = NO_DATA_CODE;
            r.masked_class       = NO_DATA_CODE;
            r.slope_masked_class = NO_DATA_CODE;
            return r;
        end
        num    = longint'(p.green) - longint'(p.swir1);
        den    = longint'(p.green) + longint'(p.swir1);
        awesh4 = 4 * longint'(p.blue) + 10 * longint'(p.green)
                 - 6 * (longint'(p.nir) + longint'(p.swir1)) - longint'(p.swir2);
        r.test_bits[0] = mndwi_above(num, den, c.wet_thr);
        r.test_bits[1] = longint'(p.green) + longint'(p.red) >
                         longint'(p.nir) + longint'(p.swir1);
        r.test_bits[2] = awesh4 > longint'(c.shadow_thr);
        r.test_bits[3] = mndwi_above(num, den, c.p1_wet) &&
                         longint'(p.swir1) < longint'(c.p1_swir_lim) &&
                         longint'(p.nir) < longint'(c.p1_nir_lim);
        r.test_bits[4] = mndwi_above(num, den, c.p2_wet) &&
                         longint'(p.swir2) < longint'(c.p2_swir_lim) &&
                         longint'(p.nir) < longint'(c.p2_nir_lim);
        r.raw_class          = water_class(r.test_bits);
        r.masked_class       = r.raw_class;
        r.slope_masked_class = (p.slope >= c.slope_lim) ? CLASS_NOT_WATER : r.raw_class;
        if (p.mask == MASK_SHADOW || p.mask == MASK_SNOW || p.mask == MASK_CLOUD) begin
            r.masked_class       = CLASS_OBSCURED;
            r.slope_masked_class = CLASS_OBSCURED;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: class %0d: %s", $time, class_count, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_pixel  px;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            load_reset_cfg();
            pending_classes.delete();
        end else begin
            if (i_cls_valid && i_cls_ready) begin
                got.no_data            = i_no_data;
                got.test_bits          = i_test_bits;
                got.raw_class          = i_raw_class;
                got.masked_class       = i_masked_class;
                got.slope_masked_class = i_slope_masked_class;
                if (pending_classes.size() == 0) begin
                    report_mismatch("transfer with no class pending");
                end else begin
                    want = pending_classes.pop_front();
                    if (got.no_data !== want.no_data)
                        report_mismatch($sformatf("no_data %b, expected %b",
                                                  got.no_data, want.no_data));
                    if (got.test_bits !== want.test_bits)
                        report_mismatch($sformatf("test_bits %b, expected %b",
                                                  got.test_bits, want.test_bits));
                    if (got.raw_class !== want.raw_class)
                        report_mismatch($sformatf("raw_class %0d, expected %0d",
                                                  got.raw_class, want.raw_class));
                    if (got.masked_class !== want.masked_class)
                        report_mismatch($sformatf("masked_class %0d, expected %0d",
                                                  got.masked_class, want.masked_class));
                    if (got.slope_masked_class !== want.slope_masked_class)
                        report_mismatch($sformatf("slope_masked_class %0d, expected %0d",
                                                  got.slope_masked_class,
                                                  want.slope_masked_class));
                end
                class_count++;
            end
            if (i_pix_valid && i_pix_ready) begin
                px.blue  = i_blue;
                px.green = i_green;
                px.red   = i_red;
                px.nir   = i_near_infrared;
                px.swir1 = i_shortwave_one;
                px.swir2 = i_shortwave_two;
                px.mask  = i_mask_code;
                px.slope = i_slope_hundredths;
                pending_classes.push_back(classify_pixel(cfg, px));
            end
            if (i_cfg_we)
                write_cfg(i_cfg_index, i_cfg_data);
        end
        o_pending <= pending_classes.size();
    end

endmodule

>>> tb/sv/surface_water_pixel_classifier_test.sv
// Testbench top of the surface water pixel classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module surface_water_pixel_classifier_test;
    import swpc_pkg::*;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int SETTING_COUNT      = 8;
    localparam int RANDOM_PER_SETTING = 175;
    localparam int HOLD_OFF_CYCLES    = 80;
    localparam int SETTLE_CYCLES      = 10;
    localparam int UNMAPPED_INDEX     = REG_FILL + 1;

    typedef enum int {SET_DEFAULTS, SET_LOWEST, SET_HIGHEST, SET_TYPICAL, SET_ANY} t_setting;
    typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_ready;
    logic signed [15:0]     blue = '0;
    logic signed [15:0]     green = '0;
    logic signed [15:0]     red = '0;
    logic signed [15:0]     nir = '0;
    logic signed [15:0]     swir1 = '0;
    logic signed [15:0]     swir2 = '0;
    logic        [7:0]      mask_code = '0;
    logic        [15:0]     slope = '0;
    logic                   cls_valid;
    logic                   cls_ready = 1'b0;
    logic                   no_data;
    logic        [4:0]      test_bits;
    logic        [7:0]      raw_class;
    logic        [7:0]      masked_class;
    logic        [7:0]      slope_masked_class;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending;

    logic signed [15:0]     cur_fill = -16'sd9999;
    logic        [15:0]     cur_slope_limit = 16'd3000;
    int                     burst_left = 0;
    bit                     sender_idles = 1'b1;
    bit                     hold_off_req = 1'b0;

    surface_water_pixel_classifier u_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_valid              (pix_valid),
        .o_ready              (pix_ready),
        .i_blue               (blue),
        .i_green              (green),
        .i_red                (red),
        .i_near_infrared      (nir),
        .i_shortwave_one      (swir1),
        .i_shortwave_two      (swir2),
        .i_mask_code          (mask_code),
        .i_slope_hundredths   (slope),
        .o_valid              (cls_valid),
        .i_ready              (cls_ready),
        .o_no_data            (no_data),
        .o_test_bits          (test_bits),
        .o_raw_class          (raw_class),
        .o_masked_class       (masked_class),
        .o_slope_masked_class (slope_masked_class),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    surface_water_class_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_pix_valid          (pix_valid),
        .i_pix_ready          (pix_ready),
        .i_blue               (blue),
        .i_green              (green),
        .i_red                (red),
        .i_near_infrared      (nir),
        .i_shortwave_one      (swir1),
        .i_shortwave_two      (swir2),
        .i_mask_code          (mask_code),
        .i_slope_hundredths   (slope),
        .i_cls_valid          (cls_valid),
        .i_cls_ready          (cls_ready),
        .i_no_data            (no_data),
        .i_test_bits          (test_bits),
        .i_raw_class          (raw_class),
        .i_masked_class       (masked_class),
        .i_slope_masked_class (slope_masked_class),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic offer_pixel(input logic signed [15:0] b, g, r, n, s1, s2,
                               input logic [7:0] mask, input logic [15:0] slp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = sender_idles ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_valid <= 1'b1;
        blue      <= b;
        green     <= g;
        red       <= r;
        nir       <= n;
        swir1     <= s1;
        swir2     <= s2;
        mask_code <= mask;
        slope     <= slp;
        do @(posedge clk); while (!pix_ready);
    endtask

    task automatic drain_classes();
        pix_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_setting(input t_setting kind);
        logic [31:0] wet, shadow, p1, p2, lim1, lim2, slope_lim, fill;
        case (kind)
            SET_DEFAULTS: begin
                wet = 403;  shadow = 0;  p1 = -14418;  p2 = -16384;
                lim1 = 98305000;  lim2 = 131073000;  slope_lim = 3000;  fill = -9999;
            end
            SET_LOWEST: begin
                wet = -32768;  shadow = -2097152;  p1 = -32768;  p2 = -32768;
                lim1 = 0;  lim2 = 0;  slope_lim = 0;  fill = -32768;
            end
            SET_HIGHEST: begin
                wet = 32767;  shadow = 2097151;  p1 = 32767;  p2 = 32767;
                lim1 = 32'hFFFF_FFFF;  lim2 = 32'hFFFF_FFFF;  slope_lim = 65535;  fill = 32767;
            end
            SET_TYPICAL: begin
                wet       = int'($urandom_range(0, 16000)) - 8000;
                shadow    = int'($urandom_range(0, 60000)) - 30000;
                p1        = int'($urandom_range(0, 16000)) - 12000;
                p2        = int'($urandom_range(0, 16000)) - 12000;
                lim1      = {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000))};
                lim2      = {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000))};
                slope_lim = $urandom_range(0, 6000);
                fill      = $urandom_range(0, 1) ? -9999 : int'($urandom_range(0, 12000)) - 1000;
            end
            default: begin
                wet = $urandom;  shadow = $urandom;  p1 = $urandom;  p2 = $urandom;
                lim1 = $urandom;  lim2 = $urandom;  slope_lim = $urandom;  fill = $urandom;
            end
        endcase
        write_reg(REG_WETNESS, wet);
        write_reg(REG_SHADOW, shadow);
        write_reg(REG_PART1_WET, p1);
        write_reg(REG_PART2_WET, p2);
        write_reg(REG_PART1_LIMITS, lim1);
        write_reg(REG_PART2_LIMITS, lim2);
        write_reg(REG_SLOPE_LIMIT, slope_lim);
        write_reg(REG_FILL, fill);
        write_reg(CFG_INDEX_W'($urandom_range(UNMAPPED_INDEX, (1 << CFG_INDEX_W) - 1)),
                  $urandom);
        cfg_we <= 1'b0;
        cur_fill        = fill[15:0];
        cur_slope_limit = slope_lim[15:0];
    endtask

    task automatic send_directed();
        logic signed [15:0] band [6];
        offer_pixel(0, 0, 0, 0, 0, 0, 8'd0, 16'd0);
        offer_pixel(0, 500, 0, 0, -500, 0, 8'd0, 16'd0);
        offer_pixel(0, -500, 0, 0, 500, 0, 8'd0, 16'd0);
        offer_pixel(100, -1000, 50, 20, -200, 10, 8'd1, 16'd100);
        offer_pixel(32767, 32767, 32767, 32767, 32767, 32767, 8'd0, 16'hFFFF);
        offer_pixel(-32768, -32768, -32768, -32768, -32768, -32768, 8'd0, 16'd0);
        offer_pixel(32767, -32768, 32767, -32768, 32767, -32768, 8'd0, 16'd2999);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, 8'd0, 16'd100);
        offer_pixel(800, 1200, 1100, 1400, 900, 800, 8'd0, 16'd2999);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, 8'd0, 16'd3000);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, MASK_SHADOW, 16'd100);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, MASK_SNOW, 16'd3000);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, MASK_CLOUD, 16'd3000);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, 8'd5, 16'd100);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, 8'd254, 16'd100);
        offer_pixel(1000, 3000, 1500, 300, 500, 200, MASK_FILL_CODE, 16'd100);
        offer_pixel(500, 800, 1000, 3000, 2500, 1800, 8'd0, 16'd0);
        for (int k = 0; k < 6; k++) begin
            foreach (band[j]) band[j] = 16'sd1234;
            band[k] = cur_fill;
            offer_pixel(band[0], band[1], band[2], band[3], band[4], band[5],
                        MASK_CLOUD, 16'd0);
        end
    endtask

    task automatic send_random_pixel();
        logic signed [15:0] band [6];
        logic        [7:0]  mask;
        logic        [15:0] slp;
        bit                 full;
        int                 pick;
        full = ($urandom_range(0, 4) == 0);
        foreach (band[k])
            band[k] = full ? 16'($urandom) : 16'(int'($urandom_range(0, 12000)) - 1000);
        if ($urandom_range(0, 9) == 0)
            band[4] = -band[1];
        if ($urandom_range(0, 11) == 0)
            band[$urandom_range(0, 5)] = cur_fill;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            mask = 8'($urandom_range(0, 1));
        else if (pick < 14)
            mask = MASK_SHADOW;
        else if (pick == 14)
            mask = MASK_SNOW;
        else if (pick == 15)
            mask = MASK_CLOUD;
        else if (pick == 16)
            mask = MASK_FILL_CODE;
        else
            mask = 8'($urandom);
        if ($urandom_range(0, 1))
            slp = cur_slope_limit + 16'($urandom_range(0, 6)) - 16'd3;
        else
            slp = 16'($urandom);
        offer_pixel(band[0], band[1], band[2], band[3], band[4], band[5], mask, slp);
    endtask

    initial begin : receiver
        t_rx_mode mode;
        int       dwell;
        int       tick;
        mode  = RX_ALWAYS;
        dwell = 0;
        tick  = 0;
        forever begin
            @(posedge clk);
            tick++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                cls_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                if (dwell == 0) begin
                    mode  = t_rx_mode'($urandom_range(RX_ALWAYS, RX_SPARSE));
                    dwell = $urandom_range(20, 300);
                end
                dwell--;
                case (mode)
                    RX_ALWAYS:   cls_ready <= 1'b1;
                    RX_HALF:     cls_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   cls_ready <= ($urandom_range(0, 9) != 0);
                    RX_PERIODIC: cls_ready <= (tick % 4 != 3);
                    default:     cls_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_setting kind;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int phase = 0; phase < SETTING_COUNT; phase++) begin
            if (phase > 0) begin
                drain_classes();
                if (phase == 1)
                    kind = SET_LOWEST;
                else if (phase == 2)
                    kind = SET_HIGHEST;
                else if (phase == 6)
                    kind = SET_DEFAULTS;
                else
                    kind = (phase % 2) ? SET_ANY : SET_TYPICAL;
                apply_setting(kind);
            end
            sender_idles = (phase % 3 != 1);
            for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
                if (i == RANDOM_PER_SETTING / 3)
                    hold_off_req = 1'b1;
                send_random_pixel();
            end
        end
        drain_classes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
src/swpc_pkg.sv
src/swpc_prep.sv
src/swpc_ratio.sv
src/swpc_class.sv
src/surface_water_pixel_classifier.sv
tb/sv/surface_water_class_checker.sv
tb/sv/surface_water_pixel_classifier_test.sv
